/* design/apid_pkg.sv */
// Shared types, constants and gain tables for the attitude PID unit.
`default_nettype none
package apid_pkg;

    localparam int ANG_W   = 16;
    localparam int MOM_W   = 24;
    localparam int FLAG_W  = 2;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int INT_W   = 32;
    localparam int ERR_W   = ANG_W + 1;
    localparam int OPA_W   = 33;
    localparam int OPB_W   = 18;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int LIMR_W  = 26;

    localparam logic [FLAG_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [FLAG_W-1:0] CLAMP_UP   = 2'd1;
    localparam logic [FLAG_W-1:0] CLAMP_LO   = 2'd2;

    localparam logic [2:0] REG_INERTIA_ROLL  = 3'd0;
    localparam logic [2:0] REG_INERTIA_PITCH = 3'd1;
    localparam logic [2:0] REG_INERTIA_YAW   = 3'd2;
    localparam logic [2:0] REG_ARM_LR        = 3'd3;
    localparam logic [2:0] REG_ARM_FB        = 3'd4;
    localparam logic [2:0] REG_TORQUE_RATIO  = 3'd5;

    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    localparam logic [1:0] MUL_LIM = 2'd0;
    localparam logic [1:0] MUL_KI  = 2'd1;
    localparam logic [1:0] MUL_MOM = 2'd2;

    // Integral gain 0.05 held with 16 fractional bits.
    localparam logic [12:0] KI_Q16 = 13'd3277;
    localparam logic [MOM_W-1:0] LIMIT_MAX = 24'd8388607;

    typedef struct packed {
        logic [2:0][CFG_W-1:0] inertia;
        logic [CFG_W-1:0]      arm_lr;
        logic [CFG_W-1:0]      arm_fb;
        logic [CFG_W-1:0]      torque_ratio;
    } cfg_t;

    typedef struct packed {
        logic [2:0][ANG_W-1:0] cmd;
        logic [2:0][ANG_W-1:0] meas;
        logic [2:0][ANG_W-1:0] rate;
        logic [ANG_W-1:0]      thrust;
    } in_item_t;

    typedef struct packed {
        logic [2:0][MOM_W-1:0]  moment;
        logic [2:0][FLAG_W-1:0] clamp;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       lim_wr;
        logic       int_upd;
        logic       u_wr;
        logic       res_wr;
        logic       out_load;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic out_hold;
    } stat_t;

    function automatic logic [4:0] kp_gain(input logic [1:0] axis);
        case (axis)
            AXIS_ROLL:  kp_gain = 5'd15;
            AXIS_PITCH: kp_gain = 5'd15;
            default:    kp_gain = 5'd4;
        endcase
    endfunction

    function automatic logic [4:0] kd_gain(input logic [1:0] axis);
        case (axis)
            AXIS_ROLL:  kd_gain = 5'd10;
            AXIS_PITCH: kd_gain = 5'd10;
            default:    kd_gain = 5'd8;
        endcase
    endfunction

endpackage
`default_nettype wire

/* design/apid_in_if.sv */
// Input channel of the attitude PID unit: one update request per transfer.
`default_nettype none
interface apid_in_if;
    import apid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] cmd_roll;
    logic signed [ANG_W-1:0] cmd_pitch;
    logic signed [ANG_W-1:0] cmd_yaw;
    logic signed [ANG_W-1:0] meas_roll;
    logic signed [ANG_W-1:0] meas_pitch;
    logic signed [ANG_W-1:0] meas_yaw;
    logic signed [ANG_W-1:0] rate_roll;
    logic signed [ANG_W-1:0] rate_pitch;
    logic signed [ANG_W-1:0] rate_yaw;
    logic        [ANG_W-1:0] thrust;

    modport source (
        output valid, cmd_roll, cmd_pitch, cmd_yaw, meas_roll, meas_pitch, meas_yaw,
               rate_roll, rate_pitch, rate_yaw, thrust,
        input  ready
    );

    modport sink (
        input  valid, cmd_roll, cmd_pitch, cmd_yaw, meas_roll, meas_pitch, meas_yaw,
               rate_roll, rate_pitch, rate_yaw, thrust,
        output ready
    );
endinterface
`default_nettype wire

/* design/apid_out_if.sv */
// Output channel of the attitude PID unit: clamped moments and clamp flags.
`default_nettype none
interface apid_out_if;
    import apid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MOM_W-1:0] moment_roll;
    logic signed [MOM_W-1:0] moment_pitch;
    logic signed [MOM_W-1:0] moment_yaw;
    logic       [FLAG_W-1:0] clamp_roll;
    logic       [FLAG_W-1:0] clamp_pitch;
    logic       [FLAG_W-1:0] clamp_yaw;

    modport source (
        output valid, moment_roll, moment_pitch, moment_yaw,
               clamp_roll, clamp_pitch, clamp_yaw,
        input  ready
    );

    modport sink (
        input  valid, moment_roll, moment_pitch, moment_yaw,
               clamp_roll, clamp_pitch, clamp_yaw,
        output ready
    );
endinterface
`default_nettype wire

/* design/apid_regs.sv */
// APB-style configuration registers of the attitude PID unit.
`default_nettype none
module apid_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [apid_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [apid_pkg::DATA_W-1:0]     pwdata,
    output logic      [apid_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    output apid_pkg::cfg_t                       cfg
);
    import apid_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inertia[0]   <= 16'd1887;
            cfg_reg.inertia[1]   <= 16'd3733;
            cfg_reg.inertia[2]   <= 16'd2181;
            cfg_reg.arm_lr       <= 16'd8192;
            cfg_reg.arm_fb       <= 16'd8323;
            cfg_reg.torque_ratio <= 16'd11534;
        end
        else if (wr_en)
        begin
            case (index)
                REG_INERTIA_ROLL:  cfg_reg.inertia[0]   <= pwdata[CFG_W-1:0];
                REG_INERTIA_PITCH: cfg_reg.inertia[1]   <= pwdata[CFG_W-1:0];
                REG_INERTIA_YAW:   cfg_reg.inertia[2]   <= pwdata[CFG_W-1:0];
                REG_ARM_LR:        cfg_reg.arm_lr       <= pwdata[CFG_W-1:0];
                REG_ARM_FB:        cfg_reg.arm_fb       <= pwdata[CFG_W-1:0];
                REG_TORQUE_RATIO:  cfg_reg.torque_ratio <= pwdata[CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_INERTIA_ROLL:  prdata = {16'd0, cfg_reg.inertia[0]};
            REG_INERTIA_PITCH: prdata = {16'd0, cfg_reg.inertia[1]};
            REG_INERTIA_YAW:   prdata = {16'd0, cfg_reg.inertia[2]};
            REG_ARM_LR:        prdata = {16'd0, cfg_reg.arm_lr};
            REG_ARM_FB:        prdata = {16'd0, cfg_reg.arm_fb};
            REG_TORQUE_RATIO:  prdata = {16'd0, cfg_reg.torque_ratio};
            default:           prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

/* design/apid_ctrl.sv */
// Sequencer of the attitude PID unit: steps limits, then each axis, then the output.
`default_nettype none
module apid_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  apid_pkg::stat_t    stat,
    output apid_pkg::cmd_t     cmd
);
    import apid_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LIM_MUL = 4'd1;
    localparam logic [3:0] S_LIM_WR  = 4'd2;
    localparam logic [3:0] S_INT     = 4'd3;
    localparam logic [3:0] S_KI_MUL  = 4'd4;
    localparam logic [3:0] S_U_SUM   = 4'd5;
    localparam logic [3:0] S_MOM_MUL = 4'd6;
    localparam logic [3:0] S_CLAMP   = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_ROLL;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.axis     = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                axis_next   = AXIS_ROLL;
                if (in_valid)
                begin
                    state_next = S_LIM_MUL;
                end
            end
            S_LIM_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LIM;
                state_next  = S_LIM_WR;
            end
            S_LIM_WR:
            begin
                cmd.lim_wr = 1'b1;
                if (axis_reg == AXIS_YAW)
                begin
                    axis_next  = AXIS_ROLL;
                    state_next = S_INT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_LIM_MUL;
                end
            end
            S_INT:
            begin
                cmd.int_upd = 1'b1;
                state_next  = S_KI_MUL;
            end
            S_KI_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KI;
                state_next  = S_U_SUM;
            end
            S_U_SUM:
            begin
                cmd.u_wr   = 1'b1;
                state_next = S_MOM_MUL;
            end
            S_MOM_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MOM;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.res_wr = 1'b1;
                if (axis_reg == AXIS_YAW)
                begin
                    axis_next  = AXIS_ROLL;
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_INT;
                end
            end
            S_OUT:
            begin
                // Wait here only while the previous result is still not taken.
                if (!stat.out_hold)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* design/apid_dp.sv */
// Datapath of the attitude PID unit: shared multiplier, integrators, limits, output register.
`default_nettype none
module apid_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  apid_pkg::cfg_t     cfg,
    input  apid_pkg::in_item_t in_item,
    input  apid_pkg::cmd_t     cmd,
    output apid_pkg::stat_t    stat,
    output logic               out_valid,
    input  wire logic          out_ready,
    output apid_pkg::out_item_t out_item
);
    import apid_pkg::*;

    in_item_t                in_reg;
    logic signed [INT_W-1:0] integ_reg [3];
    logic [FLAG_W-1:0]       flag_reg [3];
    logic [MOM_W-1:0]        lim_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OPA_W-1:0] u_reg;
    out_item_t               res_reg;
    out_item_t               out_reg;
    logic                    out_valid_reg;

    logic [1:0]              ax;
    logic signed [ERR_W-1:0] err;
    logic signed [ANG_W-1:0] rate;
    logic [FLAG_W-1:0]       flag_old;
    logic                    int_add;
    logic signed [INT_W:0]   int_sum;
    logic signed [INT_W-1:0] int_sat;
    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic [CFG_W-1:0]        lim_coef;
    logic [31:0]             prod_u;
    logic [33:0]             prod_x3;
    logic [LIMR_W-1:0]       lim_raw;
    logic [MOM_W-1:0]        lim_cap;
    logic signed [22:0]      kp_term;
    logic signed [21:0]      kd_term;
    logic signed [PROD_W-1:0] ki_full;
    logic signed [OPA_W-1:0] u_sum;
    logic signed [PROD_W-1:0] mom_full;
    logic signed [PROD_W-1:0] lim_pos;
    logic [MOM_W-1:0]        mom_sel;
    logic [FLAG_W-1:0]       flag_new;

    assign ax       = cmd.axis;
    assign err      = $signed({in_reg.cmd[ax][ANG_W-1], in_reg.cmd[ax]})
                    - $signed({in_reg.meas[ax][ANG_W-1], in_reg.meas[ax]});
    assign rate     = $signed(in_reg.rate[ax]);
    assign flag_old = flag_reg[ax];

    // Conditional integration: hold the integrator while the axis is pushed
    // further into the limit it hit last time.
    assign int_add = (flag_old == CLAMP_NONE)
                  || ((flag_old == CLAMP_UP) && err[ERR_W-1])
                  || ((flag_old == CLAMP_LO) && !err[ERR_W-1] && (err != '0));
    assign int_sum = {integ_reg[ax][INT_W-1], integ_reg[ax]}
                   + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};

    always_comb
    begin
        if (int_sum[INT_W] != int_sum[INT_W-1])
        begin
            int_sat = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                     : {1'b0, {(INT_W-1){1'b1}}};
        end
        else
        begin
            int_sat = int_sum[INT_W-1:0];
        end
    end

    always_comb
    begin
        case (ax)
            AXIS_ROLL:  lim_coef = cfg.arm_lr;
            AXIS_PITCH: lim_coef = cfg.arm_fb;
            default:    lim_coef = cfg.torque_ratio;
        endcase
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LIM:
            begin
                op_a = $signed({17'd0, in_reg.thrust});
                op_b = $signed({2'd0, lim_coef});
            end
            MUL_KI:
            begin
                op_a = $signed({integ_reg[ax][INT_W-1], integ_reg[ax]});
                op_b = $signed({5'd0, KI_Q16});
            end
            default:
            begin
                op_a = u_reg;
                op_b = $signed({2'd0, cfg.inertia[ax]});
            end
        endcase
    end

    // Thrust limits: roll and pitch are 3/256 of thrust times arm, yaw 1/2048 of
    // thrust times torque ratio, all capped at the largest 24-bit moment.
    assign prod_u  = prod_reg[31:0];
    assign prod_x3 = {2'd0, prod_u} + {1'b0, prod_u, 1'b0};
    assign lim_raw = (ax == AXIS_YAW) ? {5'd0, prod_u[31:11]} : prod_x3[33:8];
    assign lim_cap = (lim_raw > {2'd0, LIMIT_MAX}) ? LIMIT_MAX : lim_raw[MOM_W-1:0];

    assign kp_term = 23'(err) * 23'($signed({1'b0, kp_gain(ax)}));
    assign kd_term = 22'(rate) * 22'($signed({1'b0, kd_gain(ax)}));
    assign ki_full = (prod_reg + 51'sd32768) >>> 16;
    assign u_sum   = $signed({{(OPA_W-23){kp_term[22]}}, kp_term})
                   - $signed({{(OPA_W-24){kd_term[21]}}, kd_term, 2'b00})
                   + $signed(ki_full[OPA_W-1:0]);

    assign mom_full = (prod_reg + 51'sd2048) >>> 12;
    assign lim_pos  = $signed({{(PROD_W-MOM_W){1'b0}}, lim_reg[ax]});

    always_comb
    begin
        if (mom_full > lim_pos)
        begin
            mom_sel  = lim_reg[ax];
            flag_new = CLAMP_UP;
        end
        else if (mom_full < -lim_pos)
        begin
            mom_sel  = -lim_reg[ax];
            flag_new = CLAMP_LO;
        end
        else
        begin
            mom_sel  = mom_full[MOM_W-1:0];
            flag_new = CLAMP_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                integ_reg[i] <= '0;
                flag_reg[i]  <= CLAMP_NONE;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.int_upd && int_add)
            begin
                integ_reg[ax] <= int_sat;
            end
            if (cmd.res_wr)
            begin
                flag_reg[ax] <= flag_new;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_item;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        if (cmd.lim_wr)
        begin
            lim_reg[ax] <= lim_cap;
        end
        if (cmd.u_wr)
        begin
            u_reg <= u_sum;
        end
        if (cmd.res_wr)
        begin
            res_reg.moment[ax] <= mom_sel;
            res_reg.clamp[ax]  <= flag_new;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign stat.out_hold = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;
endmodule
`default_nettype wire

/* design/attitude_pid_with_anti_windup_unit.sv */
// Top level of the three-axis attitude PID unit with conditional anti-windup.
//
// Each input transfer is one controller update for roll, pitch and yaw; it gives
// exactly one output transfer with the clamped moments (Q3.20) and fresh clamp
// flags. An update steps from input transfer to the next input ready through an
// accept step, a multiply and a write for each of the three thrust limits, then
// per axis integrate, integral gain product, PID sum, inertia product and clamp,
// and a load of the output register. This sequence is set by the single shared
// 33x18 multiplier and its product register, which every product of the update
// passes through in turn. A finished result waits in the output register while
// the next update is accepted; the unit holds in its last step only if the
// previous result is still not taken. Configuration registers sit on the
// APB-style port at byte address 4*index and must be written only while the
// unit is idle.
`default_nettype none
module attitude_pid_with_anti_windup_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    apid_in_if.sink                          in_ch,
    apid_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [apid_pkg::ADDR_W-1:0] paddr,
    input  wire logic [apid_pkg::DATA_W-1:0] pwdata,
    output logic      [apid_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import apid_pkg::*;

    cfg_t      cfg;
    cmd_t      cmd;
    stat_t     stat;
    in_item_t  in_item;
    out_item_t out_item;
    logic      in_ready;
    logic      out_valid;

    assign in_item.cmd[0]  = in_ch.cmd_roll;
    assign in_item.cmd[1]  = in_ch.cmd_pitch;
    assign in_item.cmd[2]  = in_ch.cmd_yaw;
    assign in_item.meas[0] = in_ch.meas_roll;
    assign in_item.meas[1] = in_ch.meas_pitch;
    assign in_item.meas[2] = in_ch.meas_yaw;
    assign in_item.rate[0] = in_ch.rate_roll;
    assign in_item.rate[1] = in_ch.rate_pitch;
    assign in_item.rate[2] = in_ch.rate_yaw;
    assign in_item.thrust  = in_ch.thrust;
    assign in_ch.ready     = in_ready;

    assign out_ch.valid        = out_valid;
    assign out_ch.moment_roll  = out_item.moment[0];
    assign out_ch.moment_pitch = out_item.moment[1];
    assign out_ch.moment_yaw   = out_item.moment[2];
    assign out_ch.clamp_roll   = out_item.clamp[0];
    assign out_ch.clamp_pitch  = out_item.clamp[1];
    assign out_ch.clamp_yaw    = out_item.clamp[2];

    apid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );
endmodule
`default_nettype wire

/* tb/attitude_pid_with_anti_windup_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the attitude PID unit: random and directed updates, APB setup.
module attitude_pid_with_anti_windup_unit_tb;
    import apid_pkg::*;

    localparam int     REG_COUNT     = 6;
    localparam int     RESET_CYCLES  = 12;
    localparam int     MAX_GAP       = 19;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     NUM_PHASES    = 8;
    localparam int     PHASE_ITEMS   = 118;
    localparam int     HOLD_PHASE    = 2;
    localparam int     PAUSE_PHASE   = 3;
    localparam int     CYCLE_LIMIT   = 600000;

    localparam longint KP_ROLL_PITCH = 15;
    localparam longint KP_YAW        = 4;
    localparam longint KD_ROLL_PITCH = 10;
    localparam longint KD_YAW        = 8;
    localparam longint KI_NUM        = 3277;
    localparam longint LIM_CAP       = 8388607;
    localparam longint INTEG_MAX     = 64'sd2147483647;
    localparam longint INTEG_MIN     = -64'sd2147483648;

    localparam logic [ANG_W-1:0] POS_MAX    = 16'h7FFF;
    localparam logic [ANG_W-1:0] NEG_MIN    = 16'h8000;
    localparam logic [ANG_W-1:0] THRUST_MAX = 16'hFFFF;
    localparam logic [CFG_W-1:0] CFG_MAX    = 16'hFFFF;

    class moment_scoreboard;
        logic [CFG_W-1:0]  regs [REG_COUNT];
        int                integ [3];
        logic [FLAG_W-1:0] flags [3];
        out_item_t         expected_moments [$];
        int                mismatches;

        function new();
            regs[REG_INERTIA_ROLL]  = 16'd1887;
            regs[REG_INERTIA_PITCH] = 16'd3733;
            regs[REG_INERTIA_YAW]   = 16'd2181;
            regs[REG_ARM_LR]        = 16'd8192;
            regs[REG_ARM_FB]        = 16'd8323;
            regs[REG_TORQUE_RATIO]  = 16'd11534;
            for (int a = 0; a < 3; a++)
            begin
                integ[a] = 0;
                flags[a] = CLAMP_NONE;
            end
            mismatches = 0;
        endfunction

        function void set_reg(int idx, logic [CFG_W-1:0] val);
            if (idx < REG_COUNT)
                regs[idx] = val;
        endfunction

        function int outstanding();
            return expected_moments.size();
        endfunction

        // Runs one controller update on the shadow state and queues its moments.
        function void predict_update(in_item_t it);
            longint            thr;
            longint            lim [3];
            longint            e;
            longint            rate;
            longint            sum;
            longint            ki;
            longint            u;
            longint            mom;
            longint            kp;
            longint            kd;
            bit                take;
            logic [FLAG_W-1:0] nf;
            out_item_t         res;
            thr = it.thrust;
            lim[AXIS_ROLL]  = (thr * longint'(regs[REG_ARM_LR]) * 3) >>> 8;
            lim[AXIS_PITCH] = (thr * longint'(regs[REG_ARM_FB]) * 3) >>> 8;
            lim[AXIS_YAW]   = (thr * longint'(regs[REG_TORQUE_RATIO])) >>> 11;
            for (int a = 0; a < 3; a++)
            begin
                if (lim[a] > LIM_CAP)
                    lim[a] = LIM_CAP;
                e    = longint'($signed(it.cmd[a])) - longint'($signed(it.meas[a]));
                rate = longint'($signed(it.rate[a]));
                // Conditional integration: no further push into a limit that was hit.
                take = (flags[a] == CLAMP_NONE) || (flags[a] == CLAMP_UP && e < 0)
                       || (flags[a] == CLAMP_LO && e > 0);
                if (take)
                begin
                    sum = longint'(integ[a]) + e;
                    if (sum > INTEG_MAX)
                        sum = INTEG_MAX;
                    if (sum < INTEG_MIN)
                        sum = INTEG_MIN;
                    integ[a] = int'(sum);
                end
                kp  = (a == AXIS_YAW) ? KP_YAW : KP_ROLL_PITCH;
                kd  = (a == AXIS_YAW) ? KD_YAW : KD_ROLL_PITCH;
                ki  = (longint'(integ[a]) * KI_NUM + 32768) >>> 16;
                u   = kp * e - kd * (rate * 4) + ki;
                mom = (u * longint'(regs[REG_INERTIA_ROLL + a]) + 2048) >>> 12;
                nf  = CLAMP_NONE;
                if (mom > lim[a])
                begin
                    mom = lim[a];
                    nf  = CLAMP_UP;
                end
                else if (mom < -lim[a])
                begin
                    mom = -lim[a];
                    nf  = CLAMP_LO;
                end
                flags[a]      = nf;
                res.moment[a] = mom[MOM_W-1:0];
                res.clamp[a]  = nf;
            end
            expected_moments.push_back(res);
        endfunction

        function void note_mismatch(string field, longint want, longint got);
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_moments(out_item_t got);
            out_item_t want;
            string     nm;
            if (expected_moments.size() == 0)
            begin
                mismatches++;
                $error("output transfer with no update outstanding");
                return;
            end
            want = expected_moments.pop_front();
            for (int a = 0; a < 3; a++)
            begin
                nm = (a == AXIS_ROLL) ? "roll" : (a == AXIS_PITCH) ? "pitch" : "yaw";
                if (got.moment[a] !== want.moment[a])
                    note_mismatch({"moment_", nm}, longint'($signed(want.moment[a])),
                                  longint'($signed(got.moment[a])));
                if (got.clamp[a] !== want.clamp[a])
                    note_mismatch({"clamp_", nm}, longint'(want.clamp[a]),
                                  longint'(got.clamp[a]));
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    apid_in_if  in_ch ();
    apid_out_if out_ch ();

    attitude_pid_with_anti_windup_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    moment_scoreboard sb = new();

    int               tx_max;
    int               rx_max;
    bit               hold_go;
    logic             hold_rx;
    int               cycle_cnt;
    in_item_t         last_item;
    logic [CFG_W-1:0] cfg_next [REG_COUNT];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic in_item_t make_item(
        input logic [ANG_W-1:0] cr, cp, cy, mr, mp, my, rr, rp, ry, thr);
        in_item_t it;
        it.cmd[AXIS_ROLL]   = cr;
        it.cmd[AXIS_PITCH]  = cp;
        it.cmd[AXIS_YAW]    = cy;
        it.meas[AXIS_ROLL]  = mr;
        it.meas[AXIS_PITCH] = mp;
        it.meas[AXIS_YAW]   = my;
        it.rate[AXIS_ROLL]  = rr;
        it.rate[AXIS_PITCH] = rp;
        it.rate[AXIS_YAW]   = ry;
        it.thrust           = thr;
        return it;
    endfunction

    function automatic logic [ANG_W-1:0] rand_angle();
        logic [ANG_W-1:0] r;
        case ($urandom_range(0, 9))
            0:       r = POS_MAX;
            1:       r = NEG_MIN;
            2:       r = '0;
            3, 4, 5: r = 16'($urandom_range(0, 2047)) - 16'd1024;
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [ANG_W-1:0] rand_thrust();
        logic [ANG_W-1:0] r;
        case ($urandom_range(0, 7))
            0:       r = '0;
            1:       r = THRUST_MAX;
            2, 3, 4: r = 16'($urandom_range(0, 8191));
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    function automatic in_item_t rand_update();
        in_item_t it;
        if ($urandom_range(0, 1) == 1)
        begin
            // Hold commands so errors persist across updates and work the integrators
            // and clamp flags; measurements drift, rates and at times thrust change.
            it = last_item;
            for (int a = 0; a < 3; a++)
            begin
                it.meas[a] = it.meas[a] + 16'($urandom_range(0, 511)) - 16'd256;
                it.rate[a] = 16'($urandom_range(0, 4095)) - 16'd2048;
            end
            if ($urandom_range(0, 3) == 0)
                it.thrust = rand_thrust();
        end
        else
            it = make_item(rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                           rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                           rand_angle(), rand_thrust());
        last_item = it;
        return it;
    endfunction

    task automatic put_fields(input in_item_t it);
        in_ch.cmd_roll   <= it.cmd[AXIS_ROLL];
        in_ch.cmd_pitch  <= it.cmd[AXIS_PITCH];
        in_ch.cmd_yaw    <= it.cmd[AXIS_YAW];
        in_ch.meas_roll  <= it.meas[AXIS_ROLL];
        in_ch.meas_pitch <= it.meas[AXIS_PITCH];
        in_ch.meas_yaw   <= it.meas[AXIS_YAW];
        in_ch.rate_roll  <= it.rate[AXIS_ROLL];
        in_ch.rate_pitch <= it.rate[AXIS_PITCH];
        in_ch.rate_yaw   <= it.rate[AXIS_YAW];
        in_ch.thrust     <= it.thrust;
    endtask

    // Valid is only lowered when a gap follows, so back-to-back transfers keep it high.
    task automatic send_update(input in_item_t it);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        put_fields(it);
        do @(posedge clk); while (!in_ch.ready);
        sb.predict_update(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << 2);
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic apply_config();
        drain();
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, cfg_next[i]);
        // An address past the register file must leave every register alone.
        write_reg(REG_COUNT + $urandom_range(0, 1), 16'($urandom));
    endtask

    // Receiver.
    initial
    begin
        int        gap;
        out_item_t got;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rx_max);
            if (gap > 0 || hold_rx)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_rx)
                    @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.moment[AXIS_ROLL]  = out_ch.moment_roll;
            got.moment[AXIS_PITCH] = out_ch.moment_pitch;
            got.moment[AXIS_YAW]   = out_ch.moment_yaw;
            got.clamp[AXIS_ROLL]   = out_ch.clamp_roll;
            got.clamp[AXIS_PITCH]  = out_ch.clamp_pitch;
            got.clamp[AXIS_YAW]    = out_ch.clamp_yaw;
            sb.check_moments(got);
        end
    end

    // Long output stall so the unit backs up and holds off its input.
    initial
    begin
        hold_rx = 1'b0;
        wait (hold_go);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        put_fields('0);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        tx_max      = MAX_GAP;
        rx_max      = MAX_GAP;
        hold_go     = 1'b0;
        last_item   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero thrust: exact zero moment gives no flag, anything else clamps to zero.
        send_update(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_update(make_item(POS_MAX, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN,
                              '0, '0, '0, '0));
        // Upper clamp with a positive and then a zero error: the integrator holds.
        send_update(make_item(POS_MAX, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN,
                              '0, '0, '0, '0));
        send_update(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_update(make_item(NEG_MIN, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, POS_MAX,
                              '0, '0, '0, '0));
        // Lower clamp with a negative and then a zero error.
        send_update(make_item(NEG_MIN, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, POS_MAX,
                              '0, '0, '0, '0));
        send_update(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_update(make_item(POS_MAX, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN,
                              NEG_MIN, NEG_MIN, NEG_MIN, THRUST_MAX));
        send_update(make_item(NEG_MIN, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, POS_MAX,
                              POS_MAX, POS_MAX, POS_MAX, THRUST_MAX));
        send_update(make_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));

        // Largest registers: the roll and pitch limits exceed the output range.
        for (int i = 0; i < REG_COUNT; i++)
            cfg_next[i] = CFG_MAX;
        apply_config();
        send_update(make_item(POS_MAX, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN,
                              NEG_MIN, NEG_MIN, NEG_MIN, THRUST_MAX));
        send_update(make_item(NEG_MIN, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, POS_MAX,
                              POS_MAX, POS_MAX, POS_MAX, THRUST_MAX));
        send_update(make_item(16'h0100, 16'hFF00, 16'h0010, '0, '0, '0,
                              16'h0040, 16'hFFC0, '0, 16'h0001));
        send_update(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, THRUST_MAX));

        // All registers zero: no inertia and zero limits.
        for (int i = 0; i < REG_COUNT; i++)
            cfg_next[i] = '0;
        apply_config();
        send_update(make_item(POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN,
                              POS_MAX, NEG_MIN, POS_MAX, THRUST_MAX));
        send_update(make_item(16'h1234, 16'hEDCB, 16'h0777, 16'h0F00, 16'h0100, 16'hF000,
                              16'h0200, 16'hFE00, 16'h0033, 16'h0A00));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       cfg_next[i] = '0;
                    1:       cfg_next[i] = CFG_MAX;
                    2, 3:    cfg_next[i] = 16'($urandom_range(1000, 12000));
                    default: cfg_next[i] = 16'($urandom);
                endcase
            end
            apply_config();
            tx_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            rx_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            if (ph == 0)
            begin
                tx_max = MAX_GAP;
                rx_max = MAX_GAP;
            end
            else if (ph == 1)
            begin
                tx_max = 0;
                rx_max = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == HOLD_PHASE && n == PHASE_ITEMS / 2)
                begin
                    tx_max  = 0;
                    hold_go = 1'b1;
                end
                if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                    drain();
                send_update(rand_update());
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* sim.f */
design/apid_pkg.sv
design/apid_in_if.sv
design/apid_out_if.sv
design/apid_regs.sv
design/apid_ctrl.sv
design/apid_dp.sv
design/attitude_pid_with_anti_windup_unit.sv
tb/attitude_pid_with_anti_windup_unit_tb.sv
